// ===== rtl/salru_pkg.sv =====
// Shared types and constants for the set-associative cache tag model with LRU age counters.
// Used by the controller, the datapath and the top level. Depends on nothing.
package salru_pkg;

   localparam int TAG_W     = 30;
   localparam int AGE_W     = 8;
   localparam int CSR_W     = 4;
   localparam int CSR_IDX_W = 2;
   localparam int ADDR_W    = 32;
   localparam int CNT_W     = 64;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WAY_BITS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_BITS = 2'd2;

   // Uncached window, both ends inclusive.
   localparam logic [ADDR_W-1:0] WINDOW_LO = 32'h3000_0000;
   localparam logic [ADDR_W-1:0] WINDOW_HI = 32'h4000_0000;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_UPDATE
   } ctrl_state_type;

   typedef struct packed {
      logic clear_step;
      logic accept;
      logic read;
      logic update;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
   } dp_status_type;

endpackage

// ===== rtl/salru_ctrl.sv =====
// Controller state machine: memory clearing after reset, then read and update of one set per word.
// Depends on salru_pkg for the state, command and status types.
module salru_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  salru_pkg::dp_status_type status,
   output salru_pkg::ctrl_cmd_type  cmd
);

   salru_pkg::ctrl_state_type state_ff;
   salru_pkg::ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= salru_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      busy           = 1'b0;
      unique case (state_ff)
         salru_pkg::ST_CLEAR: begin
            busy           = 1'b1;
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = salru_pkg::ST_IDLE;
            end
         end
         salru_pkg::ST_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = salru_pkg::ST_READ;
            end
         end
         salru_pkg::ST_READ: begin
            busy     = 1'b1;
            cmd.read = 1'b1;
            state_in = salru_pkg::ST_UPDATE;
         end
         salru_pkg::ST_UPDATE: begin
            // The write-back lands at the end of this cycle, so a new word may be taken now.
            cmd.update = 1'b1;
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = salru_pkg::ST_READ;
            end else begin
               state_in = salru_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = salru_pkg::ST_CLEAR;
         end
      endcase
   end

endmodule

// ===== rtl/salru_dp.sv =====
// Datapath: configuration registers, address split, set memories, hit search, victim pick,
// age update, request and hit counters and the response registers. Depends on salru_pkg.
module salru_dp #(
   parameter int MAX_SET_BITS = 6,
   parameter int MAX_WAY_BITS = 2,
   parameter int AGE_MAX      = 255
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  salru_pkg::ctrl_cmd_type               cmd,
   output salru_pkg::dp_status_type              status,
   input  logic                                  csr_write_en,
   input  logic [salru_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [salru_pkg::CSR_W-1:0]           csr_wdata,
   input  logic [salru_pkg::ADDR_W-1:0]          req_address,
   output logic                                  rsp_valid,
   output logic                                  rsp_hit,
   output logic                                  rsp_bypassed,
   output logic [1:0]                            rsp_way_used,
   output logic [salru_pkg::CNT_W-1:0]           rsp_request_total,
   output logic [salru_pkg::CNT_W-1:0]           rsp_hit_total
);

   localparam int NUM_SETS = 1 << MAX_SET_BITS;
   localparam int NUM_WAYS = 1 << MAX_WAY_BITS;
   localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int WAY_W    = (MAX_WAY_BITS > 0) ? MAX_WAY_BITS : 1;
   localparam int TAG_W    = salru_pkg::TAG_W;
   localparam int AGE_W    = salru_pkg::AGE_W;

   // Configuration registers.
   logic [2:0] set_bits_ff;
   logic [1:0] way_bits_ff;
   logic [3:0] line_bits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff  <= 3'd6;
         way_bits_ff  <= 2'd2;
         line_bits_ff <= 4'd4;
      end else if (csr_write_en) begin
         unique case (csr_index)
            salru_pkg::CSR_SET_BITS:  set_bits_ff  <= csr_wdata[2:0];
            salru_pkg::CSR_WAY_BITS:  way_bits_ff  <= csr_wdata[1:0];
            salru_pkg::CSR_LINE_BITS: line_bits_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // Address of the word in progress.
   logic [salru_pkg::ADDR_W-1:0] addr_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         addr_ff <= req_address;
      end
   end

   // Field split under the current configuration, with out-of-range values clamped.
   logic [3:0]       sb;
   logic [1:0]       wb;
   logic [3:0]       lb;
   logic [4:0]       shamt;
   logic [3:0]       nways;
   logic [TAG_W-1:0] tag_q;
   logic [SET_W-1:0] set_idx;
   logic             bypass;

   always_comb begin
      if ({1'b0, set_bits_ff} > 4'(MAX_SET_BITS)) begin
         sb = 4'(MAX_SET_BITS);
      end else begin
         sb = {1'b0, set_bits_ff};
      end
      if (way_bits_ff > 2'(MAX_WAY_BITS)) begin
         wb = 2'(MAX_WAY_BITS);
      end else begin
         wb = way_bits_ff;
      end
      if (line_bits_ff < 4'd2) begin
         lb = 4'd2;
      end else if (line_bits_ff > 4'd12) begin
         lb = 4'd12;
      end else begin
         lb = line_bits_ff;
      end
      shamt   = 5'(lb) + 5'(sb);
      nways   = 4'd1 << wb;
      tag_q   = TAG_W'(addr_ff >> shamt);
      set_idx = SET_W'(addr_ff >> lb) & ~({SET_W{1'b1}} << sb);
      bypass  = (addr_ff >= salru_pkg::WINDOW_LO) && (addr_ff <= salru_pkg::WINDOW_HI);
   end

   // Set memories: one row holds every way of a set.
   logic [NUM_WAYS-1:0][TAG_W-1:0] tag_mem   [NUM_SETS];
   logic [NUM_WAYS-1:0]            valid_mem [NUM_SETS];
   logic [NUM_WAYS-1:0][AGE_W-1:0] age_mem   [NUM_SETS];

   logic [NUM_WAYS-1:0][TAG_W-1:0] tag_rd_ff;
   logic [NUM_WAYS-1:0]            valid_rd_ff;
   logic [NUM_WAYS-1:0][AGE_W-1:0] age_rd_ff;

   logic [NUM_WAYS-1:0][TAG_W-1:0] tag_wr;
   logic [NUM_WAYS-1:0]            valid_wr;
   logic [NUM_WAYS-1:0][AGE_W-1:0] age_wr;

   logic [SET_W-1:0] clr_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_idx_ff <= clr_idx_ff + 1'b1;
      end
   end

   assign status.clear_last = (clr_idx_ff == SET_W'(NUM_SETS - 1));

   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         tag_mem[clr_idx_ff]   <= '0;
         valid_mem[clr_idx_ff] <= '0;
         age_mem[clr_idx_ff]   <= '0;
      end else if (cmd.update && !bypass) begin
         tag_mem[set_idx]   <= tag_wr;
         valid_mem[set_idx] <= valid_wr;
         age_mem[set_idx]   <= age_wr;
      end
      if (cmd.read) begin
         tag_rd_ff   <= tag_mem[set_idx];
         valid_rd_ff <= valid_mem[set_idx];
         age_rd_ff   <= age_mem[set_idx];
      end
   end

   // Lookup, victim choice and ageing on the row that was read.
   logic [NUM_WAYS-1:0] active;
   logic                hit;
   logic [WAY_W-1:0]    hit_way;
   logic [WAY_W-1:0]    pick;
   logic                pick_done;
   logic [WAY_W-1:0]    way;

   always_comb begin
      for (int i = 0; i < NUM_WAYS; i++) begin
         active[i] = (4'(i) < nways);
      end

      hit     = 1'b0;
      hit_way = '0;
      for (int i = 0; i < NUM_WAYS; i++) begin
         if (!hit && active[i] && valid_rd_ff[i] && (tag_rd_ff[i] == tag_q)) begin
            hit     = 1'b1;
            hit_way = WAY_W'(i);
         end
      end

      // An older way takes over the pick; otherwise the first empty way ends the scan.
      pick      = '0;
      pick_done = 1'b0;
      for (int i = 0; i < NUM_WAYS; i++) begin
         if (!pick_done && active[i]) begin
            if (age_rd_ff[i] > age_rd_ff[pick]) begin
               pick = WAY_W'(i);
            end else if (!valid_rd_ff[i]) begin
               pick      = WAY_W'(i);
               pick_done = 1'b1;
            end
         end
      end

      way = hit ? hit_way : pick;

      tag_wr   = tag_rd_ff;
      valid_wr = valid_rd_ff;
      age_wr   = age_rd_ff;
      if (!hit) begin
         tag_wr[way]   = tag_q;
         valid_wr[way] = 1'b1;
      end
      for (int i = 0; i < NUM_WAYS; i++) begin
         if (active[i]) begin
            if (WAY_W'(i) == way) begin
               age_wr[i] = '0;
            end else if (age_rd_ff[i] < AGE_W'(AGE_MAX)) begin
               age_wr[i] = age_rd_ff[i] + 1'b1;
            end
         end
      end
   end

   // Counters and response registers.
   logic [salru_pkg::CNT_W-1:0] req_cnt_ff;
   logic [salru_pkg::CNT_W-1:0] hit_cnt_ff;
   logic                        rsp_valid_ff;
   logic                        rsp_hit_ff;
   logic                        rsp_bypassed_ff;
   logic [1:0]                  rsp_way_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_cnt_ff   <= '0;
         hit_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.update;
         if (cmd.update) begin
            req_cnt_ff <= req_cnt_ff + 1'b1;
            if (hit && !bypass) begin
               hit_cnt_ff <= hit_cnt_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rsp_hit_ff      <= hit && !bypass;
         rsp_bypassed_ff <= bypass;
         rsp_way_ff      <= bypass ? 2'd0 : 2'(way);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_bypassed      = rsp_bypassed_ff;
   assign rsp_way_used      = rsp_way_ff;
   assign rsp_request_total = req_cnt_ff;
   assign rsp_hit_total     = hit_cnt_ff;

endmodule

// ===== rtl/set_assoc_cache_lru_counters_core.sv =====
// Top level of the set-associative cache tag model with LRU age counters.
// Depends on salru_pkg, salru_ctrl and salru_dp.

// Each accepted word (start high while busy is low) is first read, then written back: the read state
// fetches the set's row of tags, valid bits and ages from the set memory, and the update state
// compares, picks the victim and writes the row back. A new word may be started in the
// write-back cycle; busy is high in the read cycle and while the set memory is cleared. The
// response appears for exactly one cycle with rsp_valid high, from the response registers
// loaded in the write-back cycle, and must be taken then. After reset the set memory is
// cleared one set per cycle, which keeps busy high until the last set is cleared.
// Configuration writes take effect at once and should only be made while no word is in flight.
module set_assoc_cache_lru_counters_core #(
   parameter int MAX_SET_BITS = 6,
   parameter int MAX_WAY_BITS = 2,
   parameter int AGE_MAX      = 255
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [salru_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [salru_pkg::CSR_W-1:0]     csr_wdata,
   input  logic                            start,
   output logic                            busy,
   input  logic [salru_pkg::ADDR_W-1:0]    req_address,
   output logic                            rsp_valid,
   output logic                            rsp_hit,
   output logic                            rsp_bypassed,
   output logic [1:0]                      rsp_way_used,
   output logic [salru_pkg::CNT_W-1:0]     rsp_request_total,
   output logic [salru_pkg::CNT_W-1:0]     rsp_hit_total
);

   salru_pkg::ctrl_cmd_type  cmd;
   salru_pkg::dp_status_type status;

   salru_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   salru_dp #(
      .MAX_SET_BITS (MAX_SET_BITS),
      .MAX_WAY_BITS (MAX_WAY_BITS),
      .AGE_MAX      (AGE_MAX)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_address       (req_address),
      .rsp_valid         (rsp_valid),
      .rsp_hit           (rsp_hit),
      .rsp_bypassed      (rsp_bypassed),
      .rsp_way_used      (rsp_way_used),
      .rsp_request_total (rsp_request_total),
      .rsp_hit_total     (rsp_hit_total)
   );

   // Every response belongs to a word accepted before its read and write-back cycles.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 3))
   else $error("response without a matching accepted word");

   // The request count steps by one with each response.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_request_total == $past(rsp_request_total) + 64'd1))
   else $error("request count did not advance by one");

   // A bypassed word never counts as a hit.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bypassed) |-> (!rsp_hit && rsp_hit_total == $past(rsp_hit_total)))
   else $error("bypassed word changed the hit count");

endmodule

// ===== verif/tb_set_assoc_cache_lru_counters_core.sv =====
// Testbench for set_assoc_cache_lru_counters_core: drives address words, predicts each response
// with its own tag, valid and age model, and checks every response field by field.
// Depends on salru_pkg and the RTL of the block.
module tb_set_assoc_cache_lru_counters_core;

   localparam int MAX_SET_BITS = 6;
   localparam int MAX_WAY_BITS = 2;
   localparam int AGE_MAX      = 255;
   localparam int NUM_ENTRIES  = (1 << MAX_SET_BITS) << MAX_WAY_BITS;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int TAG_W        = salru_pkg::TAG_W;
   localparam int AGE_W        = salru_pkg::AGE_W;
   localparam int CSR_W        = salru_pkg::CSR_W;
   localparam int CSR_IDX_W    = salru_pkg::CSR_IDX_W;
   localparam int ADDR_W       = salru_pkg::ADDR_W;
   localparam int CNT_W        = salru_pkg::CNT_W;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic             hit;
      logic             bypassed;
      logic [1:0]       way_used;
      logic [CNT_W-1:0] request_total;
      logic [CNT_W-1:0] hit_total;
   } lookup_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = salru_pkg::CSR_SET_BITS;
   logic [CSR_W-1:0]     csr_wdata = '0;
   logic                 start = 1'b0;
   logic                 busy;
   logic [ADDR_W-1:0]    req_address = '0;
   logic                 rsp_valid;
   logic                 rsp_hit;
   logic                 rsp_bypassed;
   logic [1:0]           rsp_way_used;
   logic [CNT_W-1:0]     rsp_request_total;
   logic [CNT_W-1:0]     rsp_hit_total;

   // Shadow of the cache: tags, valid bits, ages, counters and the three field widths.
   logic [TAG_W-1:0]     tag_mem   [NUM_ENTRIES];
   logic                 valid_mem [NUM_ENTRIES];
   logic [AGE_W-1:0]     age_mem   [NUM_ENTRIES];
   logic [CNT_W-1:0]     request_count = '0;
   logic [CNT_W-1:0]     hit_count = '0;
   logic [2:0]           set_bits_reg = 3'd6;
   logic [1:0]           way_bits_reg = 2'd2;
   logic [3:0]           line_bits_reg = 4'd4;

   logic [ADDR_W-1:0]    address_queue [$];
   lookup_result_type    expected_lookups [$];
   logic [ADDR_W-1:0]    recent_lines [$];
   logic [ADDR_W-1:0]    corner_addrs [0:17] = '{
      32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h2FFF_FFFF, 32'h3000_0000,
      32'h4000_0000, 32'h4000_0001, 32'h3555_5555, 32'h0000_0400, 32'h0000_0800,
      32'h0000_0C00, 32'h0000_1000, 32'h0000_0000, 32'h0000_080F, 32'hAAAA_AAAA,
      32'h5555_5555, 32'h0000_1404, 32'h0000_0000
   };

   int send_gap_pct = 30;
   int errors = 0;
   int words_sent = 0;
   int words_seen = 0;
   int hits_seen = 0;
   int bypasses_seen = 0;
   int cycle_count = 0;

   set_assoc_cache_lru_counters_core #(
      .MAX_SET_BITS(MAX_SET_BITS),
      .MAX_WAY_BITS(MAX_WAY_BITS),
      .AGE_MAX     (AGE_MAX)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .start            (start),
      .busy             (busy),
      .req_address      (req_address),
      .rsp_valid        (rsp_valid),
      .rsp_hit          (rsp_hit),
      .rsp_bypassed     (rsp_bypassed),
      .rsp_way_used     (rsp_way_used),
      .rsp_request_total(rsp_request_total),
      .rsp_hit_total    (rsp_hit_total)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Field widths in force, with out-of-range register values saturated or clamped.
   function automatic void clamp_widths(output int unsigned sb, output int unsigned wb,
                                        output int unsigned lb);
      sb = (int'(set_bits_reg) > MAX_SET_BITS) ? MAX_SET_BITS : int'(set_bits_reg);
      wb = (int'(way_bits_reg) > MAX_WAY_BITS) ? MAX_WAY_BITS : int'(way_bits_reg);
      lb = (line_bits_reg < 4'd2) ? 2 : ((line_bits_reg > 4'd12) ? 12 : int'(line_bits_reg));
   endfunction

   function automatic lookup_result_type lookup_cache(input logic [ADDR_W-1:0] addr);
      int unsigned       sb, wb, lb, nways, set_idx, base, e, p, way;
      logic [TAG_W-1:0]  tag;
      logic              found;
      lookup_result_type r;
      r = '0;
      found = 1'b0;
      way = 0;
      clamp_widths(sb, wb, lb);
      request_count = request_count + 1;
      if (addr >= salru_pkg::WINDOW_LO && addr <= salru_pkg::WINDOW_HI) begin
         r.bypassed = 1'b1;
         r.request_total = request_count;
         r.hit_total = hit_count;
         return r;
      end
      nways = 1 << wb;
      tag = TAG_W'(addr >> (lb + sb));
      set_idx = (addr >> lb) & ((1 << sb) - 1);
      base = set_idx << MAX_WAY_BITS;
      for (int unsigned i = 0; i < nways; i++) begin
         e = (base + i) % NUM_ENTRIES;
         if (!found && valid_mem[e] && tag_mem[e] == tag) begin
            found = 1'b1;
            way = i;
         end
      end
      if (!found) begin
         // The victim scan stops at the first invalid way unless an older way beats the pick.
         for (int unsigned i = 0; i < nways; i++) begin
            e = (base + i) % NUM_ENTRIES;
            p = (base + way) % NUM_ENTRIES;
            if (age_mem[e] > age_mem[p]) begin
               way = i;
            end else if (!valid_mem[e]) begin
               way = i;
               break;
            end
         end
         tag_mem[(base + way) % NUM_ENTRIES] = tag;
         valid_mem[(base + way) % NUM_ENTRIES] = 1'b1;
      end else begin
         hit_count = hit_count + 1;
      end
      age_mem[(base + way) % NUM_ENTRIES] = '0;
      for (int unsigned i = 0; i < nways; i++) begin
         e = (base + i) % NUM_ENTRIES;
         if (i != way && age_mem[e] < AGE_MAX)
            age_mem[e] = age_mem[e] + 1'b1;
      end
      r.hit = found;
      r.way_used = 2'(way);
      r.request_total = request_count;
      r.hit_total = hit_count;
      return r;
   endfunction

   // Mostly lines seen lately or small tags in a few sets, so that hits and evictions are
   // common; the rest are window addresses, the words just outside the window and fully random words.
   function automatic logic [ADDR_W-1:0] random_address();
      int unsigned       sb, wb, lb, pick, tag, set_idx;
      logic [ADDR_W-1:0] a;
      clamp_widths(sb, wb, lb);
      pick = $urandom_range(99);
      if (pick < 55 && recent_lines.size() > 0) begin
         a = recent_lines[$urandom_range(recent_lines.size() - 1)] ^ ($urandom & 32'h3);
      end else if (pick < 80) begin
         tag = $urandom_range(7);
         set_idx = $urandom_range(3) & ((1 << sb) - 1);
         a = (tag << (lb + sb)) | (set_idx << lb) | ($urandom & ((1 << lb) - 1));
      end else if (pick == 80) begin
         a = salru_pkg::WINDOW_LO;
      end else if (pick == 81) begin
         a = salru_pkg::WINDOW_HI;
      end else if (pick == 82) begin
         a = salru_pkg::WINDOW_LO - 1;
      end else if (pick == 83) begin
         a = salru_pkg::WINDOW_HI + 1;
      end else if (pick < 90) begin
         a = $urandom_range(salru_pkg::WINDOW_HI, salru_pkg::WINDOW_LO);
      end else begin
         a = $urandom;
      end
      recent_lines.push_back(a);
      if (recent_lines.size() > 16)
         void'(recent_lines.pop_front());
      return a;
   endfunction

   function automatic void check_field(input string field, input logic [CNT_W-1:0] want,
                                       input logic [CNT_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
         errors++;
      end
   endfunction

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         salru_pkg::CSR_SET_BITS:  set_bits_reg = value[2:0];
         salru_pkg::CSR_WAY_BITS:  way_bits_reg = value[1:0];
         salru_pkg::CSR_LINE_BITS: line_bits_reg = value[3:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic set_shape(input logic [CSR_W-1:0] sb, input logic [CSR_W-1:0] wb,
                            input logic [CSR_W-1:0] lb);
      write_csr(salru_pkg::CSR_SET_BITS, sb);
      write_csr(salru_pkg::CSR_WAY_BITS, wb);
      write_csr(salru_pkg::CSR_LINE_BITS, lb);
      recent_lines.delete();
   endtask

   task automatic queue_random(input int n);
      repeat (n) address_queue.push_back(random_address());
   endtask

   // The sender holds off here until every outstanding word has been answered.
   task automatic wait_drained();
      do @(negedge clock);
      while (address_queue.size() != 0 || start || expected_lookups.size() != 0);
      repeat (3) @(negedge clock);
   endtask

   // Driver: a word is taken on start high, busy low; the next is picked then or if start is low.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_lookups.push_back(lookup_cache(req_address));
            words_sent++;
         end
         if (!start || !busy) begin
            if (address_queue.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
               start <= 1'b1;
               req_address <= address_queue.pop_front();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every response must match the oldest outstanding prediction.
   always @(posedge clock) begin
      lookup_result_type want;
      if (!reset && rsp_valid) begin
         words_seen++;
         if (rsp_hit) hits_seen++;
         if (rsp_bypassed) bypasses_seen++;
         if (expected_lookups.size() == 0) begin
            $display("%0t: response with no word outstanding, request_total %0h", $time,
                     rsp_request_total);
            errors++;
         end else begin
            want = expected_lookups.pop_front();
            check_field("hit", CNT_W'(want.hit), CNT_W'(rsp_hit));
            check_field("bypassed", CNT_W'(want.bypassed), CNT_W'(rsp_bypassed));
            check_field("way_used", CNT_W'(want.way_used), CNT_W'(rsp_way_used));
            check_field("request_total", want.request_total, rsp_request_total);
            check_field("hit_total", want.hit_total, rsp_hit_total);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d responses outstanding", $time,
                  expected_lookups.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         tag_mem[i] = '0;
         valid_mem[i] = 1'b0;
         age_mem[i] = '0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset shape: window edges, all-ones and all-zeros words, a full set and an eviction.
      send_gap_pct = 30;
      foreach (corner_addrs[i]) address_queue.push_back(corner_addrs[i]);
      queue_random(60);
      wait_drained();

      // One set of four ways: hammer one line until the other ages saturate, then miss.
      set_shape(4'h0, 4'h2, 4'h2);
      address_queue.push_back(32'h0000_0000);
      address_queue.push_back(32'h0000_0100);
      address_queue.push_back(32'h0000_0200);
      address_queue.push_back(32'h0000_0300);
      repeat (260) address_queue.push_back(32'h0000_0000);
      address_queue.push_back(32'h0000_0400);
      queue_random(40);
      wait_drained();

      send_gap_pct = 66;
      set_shape(4'hF, 4'h3, 4'hF);
      queue_random(55);
      wait_drained();

      set_shape(4'h3, 4'h1, 4'hC);
      queue_random(55);
      wait_drained();

      send_gap_pct = 0;
      set_shape(4'h0, 4'h0, 4'h0);
      queue_random(55);
      wait_drained();

      write_csr(CSR_SPARE, 4'h5);
      set_shape(4'hE, 4'h2, 4'hD);
      queue_random(55);
      wait_drained();

      repeat (4) @(posedge clock);
      if (expected_lookups.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, expected_lookups.size());
         errors++;
      end
      $display("Sent %0d address words over six cache shapes; %0d responses checked.",
               words_sent, words_seen);
      $display("Responses included %0d hits and %0d uncached bypasses; %0d mismatches.",
               hits_seen, bypasses_seen, errors);
      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
